// ----- src/baro_pkg.sv -----
package baro_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned WordCntW = 5;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [CfgIdxW-1:0] CfgGroupA = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgGroupB = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgGroupC = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgOss    = 2'd3;

  localparam logic [WordW-1:0] Sign32 = 32'h8000_0000;

  typedef enum logic [1:0] {
    OP_MUL,
    OP_UDIV,
    OP_SDIV
  } baro_op_t;

  typedef struct packed {
    logic     start;
    baro_op_t op;
  } baro_req_t;

  typedef struct packed {
    logic done;
    logic busy;
  } baro_sts_t;

  function automatic logic [WordW-1:0] asr(input logic [WordW-1:0] v,
                                           input logic [WordCntW-1:0] n);
    asr = WordW'($signed(v) >>> n);
  endfunction

endpackage

// ----- src/baro_serial_unit.sv -----
module baro_serial_unit (
  input  logic                     clk,
  input  logic                     rst_n,
  input  baro_pkg::baro_req_t      req,
  input  logic [31:0]              opa,
  input  logic [31:0]              opb,
  output baro_pkg::baro_sts_t      sts,
  output logic [31:0]              res
);
  import baro_pkg::*;

  logic [WordW-1:0]    acc_r, acc_nxt;
  logic [WordW-1:0]    sa_r, sa_nxt;
  logic [WordW-1:0]    sb_r, sb_nxt;
  logic [WordW:0]      rem_r, rem_nxt;
  logic [WordCntW-1:0] cnt_r, cnt_nxt;
  logic                busy_r, busy_nxt;
  logic                done_r, done_nxt;
  logic                neg_r, neg_nxt;
  baro_op_t            op_r, op_nxt;
  logic [WordW:0]      trial;
  logic [WordW-1:0]    qv;

  always_comb begin
    acc_nxt  = acc_r;
    sa_nxt   = sa_r;
    sb_nxt   = sb_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    neg_nxt  = neg_r;
    op_nxt   = op_r;
    trial    = {rem_r[WordW-1:0], sa_r[WordW-1]} - {1'b0, sb_r};
    qv       = '0;
    if (req.start) begin
      op_nxt   = req.op;
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      acc_nxt  = '0;
      rem_nxt  = '0;
      neg_nxt  = 1'b0;
      sa_nxt   = opa;
      sb_nxt   = opb;
      if (req.op == OP_SDIV) begin
        neg_nxt = opa[WordW-1] ^ opb[WordW-1];
        sa_nxt  = opa[WordW-1] ? WordW'(-opa) : opa;
        sb_nxt  = opb[WordW-1] ? WordW'(-opb) : opb;
      end
    end else if (busy_r) begin
      unique case (op_r)
        OP_MUL: begin
          acc_nxt = sb_r[0] ? acc_r + sa_r : acc_r;
          sa_nxt  = {sa_r[WordW-2:0], 1'b0};
          sb_nxt  = {1'b0, sb_r[WordW-1:1]};
        end
        default: begin
          sa_nxt = {sa_r[WordW-2:0], 1'b0};
          if (!trial[WordW]) begin
            rem_nxt = trial;
            acc_nxt = {acc_r[WordW-2:0], 1'b1};
          end else begin
            rem_nxt = {rem_r[WordW-1:0], sa_r[WordW-1]};
            acc_nxt = {acc_r[WordW-2:0], 1'b0};
          end
        end
      endcase
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == WordCntW'(WordW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
      op_r   <= OP_MUL;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
      op_r   <= op_nxt;
    end
    acc_r <= acc_nxt;
    sa_r  <= sa_nxt;
    sb_r  <= sb_nxt;
    rem_r <= rem_nxt;
    neg_r <= neg_nxt;
  end

  always_comb begin
    res = acc_r;
    if (op_r == OP_SDIV && neg_r) res = WordW'(-acc_r);
  end

  assign sts.done = done_r;
  assign sts.busy = busy_r;

  property p_done_after_busy;
    @(posedge clk) disable iff (!rst_n) done_r |-> !busy_r && $past(busy_r);
  endproperty
  a_done_after_busy: assert property (p_done_after_busy) else $error("done without run");

  property p_no_start_busy;
    @(posedge clk) disable iff (!rst_n) busy_r && !done_r |-> !req.start;
  endproperty
  a_no_start_busy: assert property (p_no_start_busy) else $error("start while busy");

  property p_cnt_idle;
    @(posedge clk) disable iff (!rst_n) !busy_r |-> cnt_r == '0 || done_r || $past(req.start) == 1'b0;
  endproperty
  a_cnt_idle: assert property (p_cnt_idle) else $error("count off");

endmodule

// ----- src/barometer_compensation.sv -----
// Barometer compensation.
// in_ channel: one request per conversion, tdata = raw_count, tuser = mode.
// mode 0 computes and stores B5, returns temperature in 0.1 degC;
// mode 1 uses the stored B5 and the oversampling register, returns Pa.
// out_ channel: tdata = reading (signed 32), tuser = {divide_fault, kind}.
// cfg_ port: three calibration words and oversampling, to be written
// while idle by the user; the block itself does not enforce this.
// All multiplies and divides run through one shift-add / restoring unit.
// Temperature: 2 operations; pressure: 11 operations. A zero divisor
// ends early. One request in flight; in_tready drops from acceptance
// until the result is loaded into the output register. A stalled
// receiver holds the result and blocks the next request. Reset clears
// the calibration and oversampling registers, B5, the sequencer and the
// output valid; calibration reads zero.
module barometer_compensation (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // raw_count [23:0]
  input  logic        in_tuser,   // mode [0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // reading [31:0]
  output logic [1:0]  out_tuser,  // kind [0], divide_fault [1]
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_wdata
);
  import baro_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_T1, S_T2, S_T3, S_TF,
    S_P1, S_P2, S_P3, S_P4, S_P5, S_P6, S_P7, S_P8, S_P9, S_P10, S_P11, S_P12,
    S_PF, S_OUT
  } state_t;

  state_t      state_r;
  logic [63:0] ga_r, gb_r, gc_r;
  logic [1:0]  oss_r;
  logic [31:0] b5_r;
  logic        mode_r;
  logic [23:0] raw_r;
  logic [31:0] t0_r, t1_r, t2_r, t3_r;
  logic        wait_r;
  logic        fault_r;
  logic [31:0] rd_r;
  logic        ov_r;
  logic        out_load;
  baro_req_t   req;
  baro_sts_t   sts;
  logic [31:0] opa, opb, res;

  logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
  assign ac1 = {{16{ga_r[63]}}, ga_r[63:48]};
  assign ac2 = {{16{ga_r[47]}}, ga_r[47:32]};
  assign ac3 = {{16{ga_r[31]}}, ga_r[31:16]};
  assign ac4 = {16'd0, ga_r[15:0]};
  assign ac5 = {16'd0, gb_r[63:48]};
  assign ac6 = {16'd0, gb_r[47:32]};
  assign b1  = {{16{gb_r[31]}}, gb_r[31:16]};
  assign b2  = {{16{gb_r[15]}}, gb_r[15:0]};
  assign mc  = {{16{gc_r[31]}}, gc_r[31:16]};
  assign md  = {{16{gc_r[15]}}, gc_r[15:0]};

  baro_serial_unit u_unit (
    .clk(clk), .rst_n(rst_n), .req(req), .opa(opa), .opb(opb), .sts(sts), .res(res)
  );

  assign in_tready = (state_r == S_IDLE);
  assign out_load  = (state_r == S_OUT) && (!ov_r || out_tready);

  logic [31:0] b6;
  assign b6 = b5_r - 32'd4000;

  // t0: sq, t1: x1 then b3, t2: x1 then b4, t3: b7 / p
  always_comb begin
    req.start = 1'b0;
    req.op    = OP_MUL;
    opa       = '0;
    opb       = '0;
    if (!wait_r) begin
      req.start = 1'b1;
      unique case (state_r)
        S_T1: begin opa = {16'd0, raw_r[15:0]} - ac6; opb = ac5; end
        S_T2: begin opa = mc << 11; opb = t0_r; req.op = OP_SDIV; end
        S_P1: begin opa = b6; opb = b6; end
        S_P2: begin opa = b2; opb = t0_r; end
        S_P3: begin opa = ac2; opb = b6; end
        S_P4: begin opa = ac3; opb = b6; end
        S_P5: begin opa = b1; opb = t0_r; end
        S_P6: begin opa = ac4; opb = asr(t2_r + 32'd2, 5'd2) + 32'd32768; end
        S_P7: begin opa = ({8'd0, raw_r} >> (4'd8 - {2'b0, oss_r})) - t1_r;
          opb = 32'd50000 >> oss_r; end
        S_P8: begin opa = t3_r[31] ? t3_r : {t3_r[30:0], 1'b0}; opb = t2_r;
          req.op = OP_UDIV; end
        S_P9: begin opa = asr(t3_r, 5'd8); opb = asr(t3_r, 5'd8); end
        S_P10: begin opa = t0_r; opb = 32'd3038; end
        S_P11: begin opa = 32'd0 - 32'd7357; opb = t3_r; end
        default: req.start = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ga_r    <= '0;
      gb_r    <= '0;
      gc_r    <= '0;
      oss_r   <= '0;
      b5_r    <= '0;
      wait_r  <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CfgGroupA: ga_r  <= cfg_wdata;
          CfgGroupB: gb_r  <= cfg_wdata;
          CfgGroupC: gc_r  <= cfg_wdata;
          CfgOss:    oss_r <= cfg_wdata[1:0];
        endcase
      end
      if (out_load) ov_r <= 1'b1;
      else if (out_tvalid && out_tready) ov_r <= 1'b0;
      if (req.start) wait_r <= 1'b1;
      if (sts.done) wait_r <= 1'b0;
      unique case (state_r)
        S_IDLE: if (in_tvalid) begin
          mode_r  <= in_tuser;
          raw_r   <= in_tdata;
          fault_r <= 1'b0;
          rd_r    <= '0;
          state_r <= in_tuser ? S_P1 : S_T1;
        end
        S_T1: if (sts.done) begin
          t0_r    <= asr(res, 5'd15) + md;
          t1_r    <= asr(res, 5'd15);
          state_r <= S_T2;
          if (asr(res, 5'd15) + md == '0) begin
            fault_r <= 1'b1;
            state_r <= S_OUT;
          end
        end
        S_T2: if (sts.done) begin
          b5_r    <= t1_r + res;
          rd_r    <= asr(t1_r + res + 32'd8, 5'd4);
          state_r <= S_OUT;
        end
        S_P1: if (sts.done) begin t0_r <= asr(res, 5'd12); state_r <= S_P2; end
        S_P2: if (sts.done) begin t1_r <= asr(res, 5'd11); state_r <= S_P3; end
        S_P3: if (sts.done) begin
          t1_r <= asr((((ac1 << 2) + t1_r + asr(res, 5'd11)) << oss_r) + 32'd2, 5'd2);
          state_r <= S_P4;
        end
        S_P4: if (sts.done) begin t2_r <= asr(res, 5'd13); state_r <= S_P5; end
        S_P5: if (sts.done) begin t2_r <= t2_r + asr(res, 5'd16); state_r <= S_P6; end
        S_P6: if (sts.done) begin t2_r <= res >> 15; state_r <= S_P7; end
        S_P7: if (sts.done) begin
          t3_r <= res;
          state_r <= S_P8;
          if (t2_r == '0) begin
            fault_r <= 1'b1;
            state_r <= S_OUT;
          end
        end
        S_P8: if (sts.done) begin
          t3_r    <= t3_r[31] ? {res[30:0], 1'b0} : res;
          state_r <= S_P9;
        end
        S_P9: if (sts.done) begin t0_r <= res; state_r <= S_P10; end
        S_P10: if (sts.done) begin t0_r <= asr(res, 5'd16); state_r <= S_P11; end
        S_P11: if (sts.done) begin
          rd_r    <= t3_r + asr(t0_r + asr(res, 5'd16) + 32'd3791, 5'd4);
          state_r <= S_OUT;
        end
        S_OUT: if (out_load) begin
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  logic [31:0] o_rd_r;
  logic [1:0]  o_us_r;
  always_ff @(posedge clk) begin
    if (out_load) begin
      o_rd_r <= rd_r;
      o_us_r <= {fault_r, mode_r};
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = o_rd_r;
  assign out_tuser  = o_us_r;

  property p_fault_zero;
    @(posedge clk) disable iff (!rst_n) out_tvalid && out_tuser[1] |-> out_tdata == '0;
  endproperty
  a_fault_zero: assert property (p_fault_zero) else $error("fault with reading");

  property p_idle_unit;
    @(posedge clk) disable iff (!rst_n) state_r == S_IDLE |-> !sts.busy;
  endproperty
  a_idle_unit: assert property (p_idle_unit) else $error("unit busy in idle");

  property p_accept_leaves;
    @(posedge clk) disable iff (!rst_n) in_tvalid && in_tready |=> !in_tready;
  endproperty
  a_accept_leaves: assert property (p_accept_leaves) else $error("second accept");

endmodule
